// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int GEN_BITS    = 16;
    localparam int DEFER_DEPTH = 16;
    localparam int IDX_BITS    = $clog2(MAX_SLOTS);
    localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
    localparam int QIDX_BITS   = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(DEFER_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_CREATE  = 2'd0,
        FUNC_DESTROY = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_FLUSH   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DEAD     = 3'd1,
        ST_DEFERRED = 3'd2,
        ST_FULL     = 3'd3,
        ST_QFULL    = 3'd4
    } status_t;

    // Command passed from front to back.
    typedef struct packed {
        func_t                func;
        logic [IDX_BITS-1:0]  index;
        logic [GEN_BITS-1:0]  generation;
        logic                 iterating;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        status_t              status;
        logic                 is_alive;
        logic [IDX_BITS-1:0]  index;
        logic [GEN_BITS-1:0]  generation;
        logic [CNT_BITS-1:0]  live_count;
        logic                 last;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC,
        BK_FLUSH_RD,
        BK_FLUSH_EX,
        BK_OUT
    } bk_state_t;

endpackage

// ----- rtl/gha_front.sv -----
// ----------------------------------------------------------------------------
// gha_front
// Input slice and two-entry command queue feeding the execution engine.
// ----------------------------------------------------------------------------
module gha_front
    import gha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  cmd_t  in_cmd,
    output logic  cmd_valid,
    input  logic  cmd_ready,
    output cmd_t  cmd
);

    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && cnt_reg == 2'd1 |=> cnt_reg == 2'd2)
        else $error("count slip");
`endif

endmodule

// ----- rtl/gha_back.sv -----
// ----------------------------------------------------------------------------
// gha_back
// Execution engine: generation memory, free stack, deferral queue, result reg.
// ----------------------------------------------------------------------------
module gha_back
    import gha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic [GEN_BITS-1:0] gen_mem  [MAX_SLOTS];
    logic [IDX_BITS-1:0] free_mem [MAX_SLOTS];
    logic [IDX_BITS+GEN_BITS-1:0] dq_reg [DEFER_DEPTH];

    bk_state_t           state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [CNT_BITS-1:0] used_reg, used_next;
    logic [CNT_BITS-1:0] top_reg, top_next;
    logic [CNT_BITS-1:0] alive_reg, alive_next;
    logic [QCNT_BITS-1:0] dcnt_reg, dcnt_next;
    logic [QCNT_BITS-1:0] fk_reg, fk_next;
    result_t             res_reg, res_next;

    logic [GEN_BITS-1:0] gen_rd_reg;
    logic [IDX_BITS-1:0] free_rd_reg;

    logic                gen_we;
    logic [IDX_BITS-1:0] gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0] gen_wdata;
    logic                free_we;
    logic [IDX_BITS-1:0] free_waddr, free_raddr;
    logic                dq_we;

    logic [IDX_BITS+GEN_BITS-1:0] dq_entry;
    logic                alive_hit;
    logic                from_stack, can_append;

    assign dq_entry   = dq_reg[fk_reg[QIDX_BITS-1:0]];
    assign alive_hit  = ({1'b0, cur_reg.index} < used_reg) &&
                        (gen_rd_reg == cur_reg.generation);
    assign from_stack = (top_reg != '0);
    assign can_append = (used_reg < CNT_BITS'(MAX_SLOTS));
    assign cmd_ready  = (state_reg == BK_IDLE);
    assign res_valid  = (state_reg == BK_OUT);
    assign res        = res_reg;

    // Free stack top is read every cycle; the generation read for a command
    // is issued in its read cycle (a create reads the slot on top of the stack).
    always_comb
    begin
        gen_raddr  = cmd.index;
        free_raddr = IDX_BITS'(top_reg - CNT_BITS'(1));
        if (state_reg == BK_FLUSH_RD)
            gen_raddr = dq_entry[IDX_BITS+GEN_BITS-1:GEN_BITS];
        else if (state_reg == BK_READ)
            gen_raddr = (cur_reg.func == FUNC_CREATE) ? free_rd_reg : cur_reg.index;
        else if (state_reg == BK_EXEC || state_reg == BK_FLUSH_EX)
            gen_raddr = cur_reg.index;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:     if (cmd_valid) state_next = (cmd.func == FUNC_FLUSH) ?
                                                     BK_FLUSH_RD : BK_READ;
            BK_READ:     state_next = BK_EXEC;
            BK_EXEC:     state_next = BK_OUT;
            BK_FLUSH_RD: state_next = (dcnt_reg == '0) ? BK_OUT : BK_FLUSH_EX;
            BK_FLUSH_EX: state_next = BK_OUT;
            BK_OUT:      if (res_ready)
                             state_next = (fk_reg != '0 && fk_reg != dcnt_reg) ?
                                          BK_FLUSH_RD : BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next   = cur_reg;
        used_next  = used_reg;
        top_next   = top_reg;
        alive_next = alive_reg;
        dcnt_next  = dcnt_reg;
        fk_next    = fk_reg;
        res_next   = res_reg;
        gen_we     = 1'b0;
        gen_waddr  = cur_reg.index;
        gen_wdata  = gen_rd_reg + GEN_BITS'(1);
        free_we    = 1'b0;
        free_waddr = IDX_BITS'(top_reg);
        dq_we      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    fk_next  = '0;
                end
            end
            BK_READ: ;
            BK_EXEC:
            begin
                res_next.status     = ST_OK;
                res_next.is_alive   = 1'b0;
                res_next.index      = cur_reg.index;
                res_next.generation = cur_reg.generation;
                res_next.last       = 1'b1;
                unique case (cur_reg.func)
                    FUNC_CREATE:
                    begin
                        if (from_stack)
                        begin
                            top_next            = top_reg - CNT_BITS'(1);
                            res_next.index      = free_rd_reg;
                            res_next.generation = gen_rd_reg;
                            cur_next.index      = free_rd_reg;
                            alive_next          = alive_reg + CNT_BITS'(1);
                        end
                        else if (can_append)
                        begin
                            gen_we              = 1'b1;
                            gen_waddr           = IDX_BITS'(used_reg);
                            gen_wdata           = '0;
                            used_next           = used_reg + CNT_BITS'(1);
                            res_next.index      = IDX_BITS'(used_reg);
                            res_next.generation = '0;
                            alive_next          = alive_reg + CNT_BITS'(1);
                        end
                        else
                        begin
                            res_next.status     = ST_FULL;
                            res_next.index      = '0;
                            res_next.generation = '0;
                        end
                    end
                    FUNC_DESTROY:
                    begin
                        if (!alive_hit)
                            res_next.status = ST_DEAD;
                        else if (cur_reg.iterating)
                        begin
                            if (dcnt_reg == QCNT_BITS'(DEFER_DEPTH))
                                res_next.status = ST_QFULL;
                            else
                            begin
                                dq_we           = 1'b1;
                                dcnt_next       = dcnt_reg + QCNT_BITS'(1);
                                res_next.status = ST_DEFERRED;
                            end
                        end
                        else
                        begin
                            gen_we  = 1'b1;
                            free_we = (top_reg != CNT_BITS'(MAX_SLOTS));
                            if (free_we)
                                top_next = top_reg + CNT_BITS'(1);
                            if (alive_reg != '0)
                                alive_next = alive_reg - CNT_BITS'(1);
                        end
                    end
                    FUNC_QUERY:
                        res_next.is_alive = alive_hit;
                    default: ;
                endcase
                res_next.live_count = alive_next;
            end
            BK_FLUSH_RD:
            begin
                cur_next.index      = dq_entry[IDX_BITS+GEN_BITS-1:GEN_BITS];
                cur_next.generation = dq_entry[GEN_BITS-1:0];
                if (dcnt_reg == '0)
                begin
                    res_next.status     = ST_OK;
                    res_next.is_alive   = 1'b0;
                    res_next.index      = '0;
                    res_next.generation = '0;
                    res_next.live_count = alive_reg;
                    res_next.last       = 1'b1;
                end
            end
            BK_FLUSH_EX:
            begin
                res_next.status     = alive_hit ? ST_OK : ST_DEAD;
                res_next.is_alive   = 1'b0;
                res_next.index      = cur_reg.index;
                res_next.generation = cur_reg.generation;
                if (alive_hit)
                begin
                    gen_we  = 1'b1;
                    free_we = (top_reg != CNT_BITS'(MAX_SLOTS));
                    if (free_we)
                        top_next = top_reg + CNT_BITS'(1);
                    if (alive_reg != '0)
                        alive_next = alive_reg - CNT_BITS'(1);
                end
                res_next.live_count = alive_next;
                fk_next             = fk_reg + QCNT_BITS'(1);
                res_next.last       = (fk_next == dcnt_reg);
                if (fk_next == dcnt_reg)
                begin
                    dcnt_next = '0;
                    fk_next   = '0;
                end
            end
            BK_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            used_reg  <= '0;
            top_reg   <= '0;
            alive_reg <= '0;
            dcnt_reg  <= '0;
            fk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            top_reg   <= top_next;
            alive_reg <= alive_next;
            dcnt_reg  <= dcnt_next;
            fk_reg    <= fk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        res_reg     <= res_next;
        gen_rd_reg  <= gen_mem[gen_raddr];
        free_rd_reg <= free_mem[free_raddr];
        if (gen_we)
            gen_mem[gen_waddr] <= gen_wdata;
        if (free_we)
            free_mem[free_waddr] <= cur_reg.index;
        if (dq_we)
            dq_reg[dcnt_reg[QIDX_BITS-1:0]] <= {cur_reg.index, cur_reg.generation};
    end

`ifndef NO_ASSERTIONS
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_BITS'(MAX_SLOTS)) else $error("free stack overrun");
    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= QCNT_BITS'(DEFER_DEPTH)) else $error("deferral overrun");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("result changed while stalled");
`endif

endmodule

// ----- rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot/generation handle allocator with LIFO reuse and deferred destroys.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command transaction per item: func (create, destroy,
//   query, flush), a handle and the iterating flag. m_axis returns results;
//   every command gives one result except flush, which gives one per queued
//   destroy (one when none are queued), with tlast on the final one.
//   Sequence: a command enters a two-entry queue; the engine takes it from
//   there when idle, spends a read state (generation memory and free stack)
//   and an execute state, then offers the result on m_axis.
//   The engine handles one command at a time through take, read, execute
//   and output states, plus output wait. A flush steps through queue read,
//   execute and output for each queued entry.
//   The engine is sequential: each command finishes its result transaction
//   before the next one is taken.
//   Reset clears slot count, free-stack top, live count and deferral count;
//   the memories are not cleared and are only read where written.
//   A stalled m_axis holds its result; the engine waits and the command
//   queue keeps taking up to two transactions before s_axis_tready drops.
// ----------------------------------------------------------------------------
module generational_handle_allocator
    import gha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] func, [11:2] handle_index, [27:12] handle_generation, zero pad
    input  logic [31:0] s_axis_tdata,
    // [0] iterating
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] is_alive, [13:4] out_index, [29:14] out_generation,
    // [40:30] live_count, zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    cmd_t    in_cmd, cmd;
    logic    cmd_valid, cmd_ready;
    result_t res;

    assign in_cmd.func       = func_t'(s_axis_tdata[1:0]);
    assign in_cmd.index      = s_axis_tdata[11:2];
    assign in_cmd.generation = s_axis_tdata[27:12];
    assign in_cmd.iterating  = s_axis_tuser;

    gha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {7'd0, res.live_count, res.generation, res.index,
                           res.is_alive, res.status};
    assign m_axis_tlast = res.last;

endmodule

// ----- tb/sv/generational_handle_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_checker
// Watches both stream channels, keeps its own handle table and compares.
// ----------------------------------------------------------------------------
module generational_handle_allocator_checker
    import gha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        logic [GEN_BITS-1:0] generation;
    } handle_t;

    logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
    logic [IDX_BITS-1:0] free_slots [MAX_SLOTS];
    int                  used_slots;
    int                  free_depth;
    int                  live_handles;
    handle_t             parked [DEFER_DEPTH];
    int                  parked_count;
    result_t             want_q [$];

    assign pending = want_q.size();

    function automatic bit is_live(logic [IDX_BITS-1:0] idx, logic [GEN_BITS-1:0] g);
        return (int'(idx) < used_slots) && (gen_mem[idx] == g);
    endfunction

    function automatic void retire(logic [IDX_BITS-1:0] idx);
        gen_mem[idx] = gen_mem[idx] + 1'b1;
        if (free_depth < MAX_SLOTS)
        begin
            free_slots[free_depth] = idx;
            free_depth++;
        end
        if (live_handles > 0)
            live_handles--;
    endfunction

    function automatic void push_result(status_t st, logic alive,
                                        logic [IDX_BITS-1:0] idx,
                                        logic [GEN_BITS-1:0] g, logic lst);
        result_t r;
        r.status     = st;
        r.is_alive   = alive;
        r.index      = idx;
        r.generation = g;
        r.live_count = live_handles[CNT_BITS-1:0];
        r.last       = lst;
        want_q.insert(want_q.size(), r);
    endfunction

    // Advance the handle table by one command and queue its results.
    function automatic void predict_command(func_t fn, logic [IDX_BITS-1:0] idx,
                                            logic [GEN_BITS-1:0] g, logic iter);
        logic [IDX_BITS-1:0] slot;
        int                  n;
        case (fn)
            FUNC_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot = free_slots[free_depth];
                end
                else if (used_slots < MAX_SLOTS)
                begin
                    slot = used_slots[IDX_BITS-1:0];
                    gen_mem[slot] = '0;
                    used_slots++;
                end
                else
                begin
                    push_result(ST_FULL, 1'b0, '0, '0, 1'b1);
                    return;
                end
                live_handles++;
                push_result(ST_OK, 1'b0, slot, gen_mem[slot], 1'b1);
            end
            FUNC_DESTROY:
            begin
                if (!is_live(idx, g))
                    push_result(ST_DEAD, 1'b0, idx, g, 1'b1);
                else if (iter && parked_count >= DEFER_DEPTH)
                    push_result(ST_QFULL, 1'b0, idx, g, 1'b1);
                else if (iter)
                begin
                    parked[parked_count] = '{index: idx, generation: g};
                    parked_count++;
                    push_result(ST_DEFERRED, 1'b0, idx, g, 1'b1);
                end
                else
                begin
                    retire(idx);
                    push_result(ST_OK, 1'b0, idx, g, 1'b1);
                end
            end
            FUNC_QUERY:
                push_result(ST_OK, is_live(idx, g), idx, g, 1'b1);
            default:
            begin
                n = parked_count;
                if (n == 0)
                    push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                for (int k = 0; k < n; k++)
                begin
                    if (is_live(parked[k].index, parked[k].generation))
                    begin
                        retire(parked[k].index);
                        push_result(ST_OK, 1'b0, parked[k].index,
                                    parked[k].generation, k == n - 1);
                    end
                    else
                        push_result(ST_DEAD, 1'b0, parked[k].index,
                                    parked[k].generation, k == n - 1);
                end
                parked_count = 0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            used_slots   = 0;
            free_depth   = 0;
            live_handles = 0;
            parked_count = 0;
            fail_count   = 0;
            want_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_command(func_t'(s_axis_tdata[1:0]), s_axis_tdata[11:2],
                                s_axis_tdata[27:12], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status     = status_t'(m_axis_tdata[2:0]);
                got.is_alive   = m_axis_tdata[3];
                got.index      = m_axis_tdata[13:4];
                got.generation = m_axis_tdata[29:14];
                got.live_count = m_axis_tdata[40:30];
                got.last       = m_axis_tlast;
                if (want_q.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = want_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.is_alive != want.is_alive)
                        report_mismatch("is_alive", got.is_alive, want.is_alive);
                    if (got.index != want.index)
                        report_mismatch("out_index", got.index, want.index);
                    if (got.generation != want.generation)
                        report_mismatch("out_generation", got.generation,
                                        want.generation);
                    if (got.live_count != want.live_count)
                        report_mismatch("live_count", got.live_count,
                                        want.live_count);
                    if (got.last != want.last)
                        report_mismatch("tlast", got.last, want.last);
                    if (m_axis_tdata[47:41] != '0)
                        report_mismatch("pad bits", m_axis_tdata[47:41], 0);
                end
            end
        end
    end

endmodule

// ----- tb/sv/generational_handle_allocator_test.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_test
// Drives create, destroy, query and flush commands with bursty traffic and
// a stalling receiver; the checker predicts every result and counts errors.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;
    import gha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;   // idle cycles before giving up
    localparam int DRAIN_WAIT  = 20;      // tail cycles after last result

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;

    // Shadow of handles handed out so that destroys and queries mostly hit.
    logic [IDX_BITS+GEN_BITS-1:0] known_handles [$];
    bit          hold_off = 1'b0;     // long receiver stall in progress
    bit          stim_done = 1'b0;
    int          idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    generational_handle_allocator u_top (.*);

    generational_handle_allocator_checker u_check (.*);

    // Capture the handle of every OK result (up to 64) for later reuse in commands.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == ST_OK
            && known_handles.size() < 64)
            known_handles.insert(known_handles.size(),
                                 {m_axis_tdata[13:4], m_axis_tdata[29:14]});

    // Send one command; the sender keeps tvalid high across back-to-back sends.
    task automatic send_cmd(func_t fn, logic [IDX_BITS-1:0] idx,
                            logic [GEN_BITS-1:0] g, logic iter);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, g, idx, fn};
        s_axis_tuser  <= iter;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic go_idle(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Pick a handle that is probably live, stale or wholly random.
    task automatic send_handle_cmd(func_t fn, logic iter);
        logic [IDX_BITS+GEN_BITS-1:0] h;
        int                           pick;
        int                           sel;
        sel = $urandom_range(9);
        if (known_handles.size() > 0 && sel < 7)
        begin
            pick = $urandom_range(known_handles.size() - 1);
            h = known_handles[pick];
            if (sel < 5)
                known_handles.delete(pick);
            if (sel == 6)
                h[GEN_BITS-1:0] = h[GEN_BITS-1:0] + 1'b1;   // freed-slot handle
        end
        else
            h = (IDX_BITS+GEN_BITS)'($urandom);
        send_cmd(fn, h[IDX_BITS+GEN_BITS-1:GEN_BITS], h[GEN_BITS-1:0], iter);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (((int'($realtime) / 1000) % 4) < 2)
            m_axis_tready <= 1'b1;            // stretches with no stall
        else
            m_axis_tready <= ($urandom_range(3) != 0);
    end

    initial
    begin
        repeat (4)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (300)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on acceptance-free cycles.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !stim_done)
        begin
            $display("generational_handle_allocator regression: fail");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int sel;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty flush, dead destroys at field extremes, creates,
        // query on live and freed slot, deferral, queue overflow, flush.
        send_cmd(FUNC_FLUSH, '1, '1, 1'b1);
        send_cmd(FUNC_DESTROY, '0, '0, 1'b0);
        send_cmd(FUNC_DESTROY, '1, '1, 1'b1);
        send_cmd(FUNC_QUERY, '1, '1, 1'b0);
        for (int k = 0; k < 18; k++)
            send_cmd(FUNC_CREATE, '0, '0, 1'b0);
        send_cmd(FUNC_QUERY, 10'd0, 16'd0, 1'b0);
        send_cmd(FUNC_DESTROY, 10'd0, 16'd0, 1'b0);
        send_cmd(FUNC_QUERY, 10'd0, 16'd1, 1'b0);    // freed slot reads live
        send_cmd(FUNC_DESTROY, 10'd0, 16'd0, 1'b0);  // now stale
        wait_drained();
        for (int k = 1; k < 18; k++)
            send_cmd(FUNC_DESTROY, k[IDX_BITS-1:0], 16'd0, 1'b1);
        send_cmd(FUNC_DESTROY, 10'd5, 16'd0, 1'b1);  // queue already full
        send_cmd(FUNC_FLUSH, '0, '0, 1'b0);
        wait_drained();                              // sender pause
        known_handles.delete();

        // Random: mostly creates and hits, occasional deferral windows.
        for (int n = 0; n < 360; )
        begin
            burst = $urandom_range(12, 1);
            for (int b = 0; b < burst; b++, n++)
            begin
                sel = $urandom_range(99);
                if (sel < 35)
                    send_cmd(FUNC_CREATE, IDX_BITS'($urandom), GEN_BITS'($urandom),
                             1'($urandom));
                else if (sel < 65)
                    send_handle_cmd(FUNC_DESTROY, ($urandom_range(2) == 0));
                else if (sel < 90)
                    send_handle_cmd(FUNC_QUERY, 1'($urandom));
                else
                    send_cmd(FUNC_FLUSH, IDX_BITS'($urandom), GEN_BITS'($urandom),
                             1'($urandom));
            end
            if ($urandom_range(2) != 0)
                go_idle($urandom_range(6, 1));
        end

        // Replay whatever is still deferred, then drain.
        wait_drained();
        send_cmd(FUNC_FLUSH, '0, '0, 1'b0);
        wait_drained();
        stim_done = 1'b1;
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("generational_handle_allocator regression: pass");
        else
            $display("generational_handle_allocator regression: fail");
        $finish;
    end

endmodule
